// File: hdl/keyword_trie_matcher_macros.svh
// Assertion macros for the keyword trie matcher.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef KEYWORD_TRIE_MATCHER_MACROS_SVH
`define KEYWORD_TRIE_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ktm_pkg.sv
// Shared types and constants for the keyword trie matcher.
// No dependencies; imported by the interfaces, the store and the top level.
package ktm_pkg;

  localparam int ENTRY_ID_W = 16;
  localparam int FOUND_ID_W = 16;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MATCH   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_PENDING   = 3'd0,
    ST_MATCH     = 3'd1,
    ST_LOST      = 3'd2,
    ST_ADDED     = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5
  } ktm_status_t;

  // Port strobes from the sequencer to the trie store.
  typedef struct packed {
    logic child_rd;
    logic child_wr;
    logic node_rd;
    logic node_wr;
  } ktm_mem_ctl_t;

endpackage

// File: hdl/ktm_if.sv
// Valid/ready channel interfaces for the keyword trie matcher.
// Depends on ktm_pkg for the payload widths and the status type.
interface ktm_in_if import ktm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [BYTE_W-1:0]     byte_value;
  logic                  last_of_tag;
  logic [ENTRY_ID_W-1:0] entry_id;

  modport source (output valid, mode, byte_value, last_of_tag, entry_id, input ready);
  modport sink   (input valid, mode, byte_value, last_of_tag, entry_id, output ready);
endinterface

interface ktm_out_if import ktm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  ktm_status_t           status;
  logic [FOUND_ID_W-1:0] found_id;

  modport source (output valid, status, found_id, input ready);
  modport sink   (input valid, status, found_id, output ready);
endinterface

// File: hdl/keyword_trie_matcher.sv
// Keyword trie matcher: tags are added one byte per transaction and later matched byte by byte.
// After reset the child table is swept clear, one entry a cycle, over its NODES*256 entries
// (65536 at the defaults); no input transaction is accepted until the sweep finishes.
// A byte then reads the child table; when only that read is needed (walking, allocating a node,
// lost match, pool full) the result follows from it, and when the reached node's id record must
// also be read (any match byte that finds a child, or the last byte of a tag that lands on an
// existing node) a node record read follows it. The two synchronous reads are dependent, child
// table then node record, and the result is registered after the last of them. Restart and
// the unused mode read nothing, their result registered at the accepting edge. A new
// transaction is taken while the previous result still waits at the output register; a
// result that finishes while the output is still full is parked and input is refused until
// the output is taken.
// Depends on ktm_pkg, ktm_if and ktm_store.
`include "keyword_trie_matcher_macros.svh"

module keyword_trie_matcher import ktm_pkg::*; #(
  parameter int NODES   = 256,
  parameter int ID_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ktm_in_if.sink     in_chan,
  ktm_out_if.source  out_chan
);

  localparam int NODE_W  = $clog2(NODES);
  localparam int CHILD_W = NODE_W + BYTE_W;
  localparam int USED_W  = NODE_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_CHILD, S_NODE, S_EMIT} state_t;

  state_t                state_r, state_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic                  last_r, last_nxt;
  logic [ID_BITS-1:0]    eid_r, eid_nxt;
  logic [NODE_W-1:0]     ins_cur_r, ins_cur_nxt;
  logic [NODE_W-1:0]     mat_cur_r, mat_cur_nxt;
  logic [NODE_W-1:0]     tgt_r, tgt_nxt;
  logic [USED_W-1:0]     nodes_used_r, nodes_used_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ktm_status_t           out_status_r, out_status_nxt;
  logic [FOUND_ID_W-1:0] out_id_r, out_id_nxt;
  ktm_status_t           res_status_r, res_status_nxt;
  logic [FOUND_ID_W-1:0] res_id_r, res_id_nxt;

  ktm_mem_ctl_t          ctl;
  logic [CHILD_W-1:0]    child_addr;
  logic [NODE_W-1:0]     child_wdata;
  logic [NODE_W-1:0]     child_rdata;
  logic [NODE_W-1:0]     node_addr;
  logic [ID_BITS:0]      node_wdata;
  logic [ID_BITS:0]      node_rdata;
  logic                  clr_done;

  logic                  in_ready;
  logic                  accept;
  logic                  out_free;
  logic                  pool_full;
  logic [ID_BITS+ENTRY_ID_W-1:0] eid_ext;
  logic [ID_BITS+FOUND_ID_W-1:0] nid_ext;
  logic [ID_BITS-1:0]    in_eid;
  logic [FOUND_ID_W-1:0] node_found;

  ktm_store #(
    .NODES   (NODES),
    .ID_BITS (ID_BITS)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .child_addr  (child_addr),
    .child_wdata (child_wdata),
    .child_rdata (child_rdata),
    .node_addr   (node_addr),
    .node_wdata  (node_wdata),
    .node_rdata  (node_rdata),
    .clr_done    (clr_done)
  );

  assign in_ready = (state_r == S_IDLE) && clr_done;
  assign accept   = in_chan.valid && in_ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign pool_full = (nodes_used_r == USED_W'(NODES));

  assign eid_ext    = {{ID_BITS{1'b0}}, in_chan.entry_id};
  assign in_eid     = eid_ext[ID_BITS-1:0];
  assign nid_ext    = {{FOUND_ID_W{1'b0}}, node_rdata[ID_BITS-1:0]};
  assign node_found = nid_ext[FOUND_ID_W-1:0];

  always_comb begin
    logic                  done;
    ktm_status_t           fin_status;
    logic [FOUND_ID_W-1:0] fin_id;

    done           = 1'b0;
    fin_status     = ST_PENDING;
    fin_id         = '0;
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    eid_nxt        = eid_r;
    ins_cur_nxt    = ins_cur_r;
    mat_cur_nxt    = mat_cur_r;
    tgt_nxt        = tgt_r;
    nodes_used_nxt = nodes_used_r;
    out_valid_nxt  = out_chan.ready ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    ctl            = '0;
    child_addr     = '0;
    child_wdata    = '0;
    node_addr      = '0;
    node_wdata     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt = in_chan.mode;
          byte_nxt = in_chan.byte_value;
          last_nxt = in_chan.last_of_tag;
          eid_nxt  = in_eid;
          if (in_chan.mode == MODE_ADD) begin
            ctl.child_rd = 1'b1;
            child_addr   = {ins_cur_r, in_chan.byte_value};
            state_nxt    = S_CHILD;
          end else if (in_chan.mode == MODE_MATCH) begin
            ctl.child_rd = 1'b1;
            child_addr   = {mat_cur_r, in_chan.byte_value};
            state_nxt    = S_CHILD;
          end else begin
            if (in_chan.mode == MODE_RESTART) begin
              mat_cur_nxt = '0;
            end
            done = 1'b1;
          end
        end
      end
      S_CHILD: begin
        if (mode_r == MODE_ADD) begin
          if (child_rdata == '0) begin
            if (pool_full) begin
              fin_status = ST_FULL;
              if (last_r) begin
                ins_cur_nxt = '0;
              end
            end else begin
              // Allocate the next free node and give it a fresh record.
              ctl.child_wr   = 1'b1;
              child_addr     = {ins_cur_r, byte_r};
              child_wdata    = nodes_used_r[NODE_W-1:0];
              ctl.node_wr    = 1'b1;
              node_addr      = nodes_used_r[NODE_W-1:0];
              node_wdata     = {last_r, eid_r};
              nodes_used_nxt = nodes_used_r + 1'b1;
              ins_cur_nxt    = last_r ? '0 : nodes_used_r[NODE_W-1:0];
              fin_status     = last_r ? ST_ADDED : ST_PENDING;
            end
            done = 1'b1;
          end else if (!last_r) begin
            ins_cur_nxt = child_rdata;
            done        = 1'b1;
          end else begin
            ctl.node_rd = 1'b1;
            node_addr   = child_rdata;
            tgt_nxt     = child_rdata;
            state_nxt   = S_NODE;
          end
        end else begin
          if (child_rdata == '0) begin
            fin_status = ST_LOST;
            done       = 1'b1;
          end else begin
            mat_cur_nxt = child_rdata;
            ctl.node_rd = 1'b1;
            node_addr   = child_rdata;
            tgt_nxt     = child_rdata;
            state_nxt   = S_NODE;
          end
        end
      end
      S_NODE: begin
        if (mode_r == MODE_ADD) begin
          ins_cur_nxt = '0;
          if (node_rdata[ID_BITS]) begin
            fin_status = ST_DUPLICATE;
            fin_id     = node_found;
          end else begin
            ctl.node_wr = 1'b1;
            node_addr   = tgt_r;
            node_wdata  = {1'b1, eid_r};
            fin_status  = ST_ADDED;
          end
        end else if (node_rdata[ID_BITS]) begin
          fin_status = ST_MATCH;
          fin_id     = node_found;
        end
        done = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished result goes straight to the output register if it is free.
    if (done) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fin_status;
        out_id_nxt     = fin_id;
        state_nxt      = S_IDLE;
      end else begin
        res_status_nxt = fin_status;
        res_id_nxt     = fin_id;
        state_nxt      = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ins_cur_r    <= '0;
      mat_cur_r    <= '0;
      nodes_used_r <= USED_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ins_cur_r    <= ins_cur_nxt;
      mat_cur_r    <= mat_cur_nxt;
      nodes_used_r <= nodes_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    byte_r       <= byte_nxt;
    last_r       <= last_nxt;
    eid_r        <= eid_nxt;
    tgt_r        <= tgt_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
  end

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.found_id = out_id_r;

  `KTM_ASSERT_NOW(a_no_accept_while_clearing, accept, clr_done, "accepted during sweep")
  `KTM_ASSERT_NOW(a_pool_bounds, 1'b1, (nodes_used_r != '0) && (nodes_used_r <= USED_W'(NODES)), "node count")
  `KTM_ASSERT_NEXT(a_alloc_counts, ctl.child_wr, nodes_used_r == $past(nodes_used_r) + USED_W'(1), "no count")
  `KTM_ASSERT_NEXT(a_result_kept, (state_r == S_EMIT) && !out_free, (state_r == S_EMIT) && out_valid_r, "lost")

endmodule

// File: hdl/ktm_store.sv
// Trie storage: the child table with its post-reset clearing sweep, and the
// per-node record memory holding {has_id, id}. Depends on ktm_pkg.
module ktm_store import ktm_pkg::*; #(
  parameter int NODES   = 256,
  parameter int ID_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ktm_mem_ctl_t                  ctl,
  input  logic [$clog2(NODES)+BYTE_W-1:0] child_addr,
  input  logic [$clog2(NODES)-1:0]      child_wdata,
  output logic [$clog2(NODES)-1:0]      child_rdata,
  input  logic [$clog2(NODES)-1:0]      node_addr,
  input  logic [ID_BITS:0]              node_wdata,
  output logic [ID_BITS:0]              node_rdata,
  output logic                          clr_done
);

  localparam int NODE_W  = $clog2(NODES);
  localparam int CHILD_W = NODE_W + BYTE_W;
  localparam int DEPTH   = NODES * (2 ** BYTE_W);

  logic [NODE_W-1:0]  child_mem [DEPTH];
  logic [ID_BITS:0]   node_mem  [NODES];

  logic [CHILD_W-1:0] clr_cnt_r;
  logic               clr_done_r;
  logic               cwe;
  logic [CHILD_W-1:0] cwa;
  logic [NODE_W-1:0]  cwd;

  // Until the sweep has zeroed every entry, the write port belongs to it.
  always_comb begin
    if (!clr_done_r) begin
      cwe = 1'b1;
      cwa = clr_cnt_r;
      cwd = '0;
    end else begin
      cwe = ctl.child_wr;
      cwa = child_addr;
      cwd = child_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == CHILD_W'(DEPTH - 1)) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      child_mem[cwa] <= cwd;
    end
    if (ctl.child_rd) begin
      child_rdata <= child_mem[child_addr];
    end
  end

  // Records are rewritten when a node is allocated, so they need no clearing.
  always_ff @(posedge clk) begin
    if (ctl.node_wr) begin
      node_mem[node_addr] <= node_wdata;
    end
    if (ctl.node_rd) begin
      node_rdata <= node_mem[node_addr];
    end
  end

  assign clr_done = clr_done_r;

endmodule
